[rtl/core/assert_macros.svh]
// Assertion macros shared by the spanning tree engine modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mst_pkg.sv]
// Package of the spanning tree engine: sizes, codes, request/result types,
// controller states and the command/status bundles. No dependencies.
package mst_pkg;

  localparam int VERTICES  = 32;
  localparam int VTX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = 2 * VTX_W;
  localparam int WGT_W     = 16;
  localparam int SUM_W     = 21;

  localparam logic [CNT_W-1:0] VtxCount = CNT_W'(VERTICES);
  localparam logic [SUM_W-1:0] SumMax   = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2
  } mst_action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD2,
    ST_SCAN,
    ST_EMIT
  } mst_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
    logic [WGT_W-1:0] edge_weight;
  } mst_req_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] tree_vertex;
    logic [VTX_W-1:0] parent_vertex;
    logic [WGT_W-1:0] tree_weight;
    logic [SUM_W-1:0] total_weight;
    logic             last;
  } mst_res_t;

  typedef struct packed {
    logic add_a;      // write first matrix entry, latch the request
    logic add_b;      // write mirrored entry
    logic clr_write;  // write zero at clear pointer
    logic run_init;   // start a run
    logic scan_issue; // walk the current row
    logic emit;       // load result register, close the step
  } mst_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic out_free;
    logic last_step;
  } mst_sts_t;

  // Vertex count in use: 0 acts as 1, above VERTICES acts as VERTICES.
  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > VtxCount) r = VtxCount;
    return r;
  endfunction

endpackage

[rtl/core/mst_if.sv]
// Valid/ready channel interfaces of the spanning tree engine.
// Depends on mst_pkg for field widths.
interface mst_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [mst_pkg::VTX_W-1:0] src_vertex;
  logic [mst_pkg::VTX_W-1:0] dst_vertex;
  logic [mst_pkg::WGT_W-1:0] edge_weight;

  modport source (output valid, action, src_vertex, dst_vertex, edge_weight, input ready);
  modport sink   (input valid, action, src_vertex, dst_vertex, edge_weight, output ready);
endinterface

interface mst_res_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [mst_pkg::VTX_W-1:0] tree_vertex;
  logic [mst_pkg::VTX_W-1:0] parent_vertex;
  logic [mst_pkg::WGT_W-1:0] tree_weight;
  logic [mst_pkg::SUM_W-1:0] total_weight;
  logic                     last;

  modport source (output valid, found, tree_vertex, parent_vertex, tree_weight,
                  total_weight, last, input ready);
  modport sink   (input valid, found, tree_vertex, parent_vertex, tree_weight,
                  total_weight, last, output ready);
endinterface

interface mst_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [mst_pkg::CNT_W-1:0] num_vertices;

  modport source (output valid, num_vertices, input ready);
  modport sink   (input valid, num_vertices, output ready);
endinterface

[rtl/core/mst_ctrl.sv]
// Sequencer of the spanning tree engine: clear sweep, edge writes and run steps.
// Depends on mst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [1:0]        req_action_i,
  output logic              req_ready_o,
  input  mst_pkg::mst_sts_t sts_i,
  output mst_pkg::mst_cmd_t cmd_o
);
  import mst_pkg::*;

  mst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_action_i)
            ACT_ADD:   state_d = ST_ADD2;
            ACT_RUN:   state_d = ST_SCAN;
            ACT_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD2: state_d = ST_IDLE;
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.last_step ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_write = 1'b1;
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req_action_i)
            ACT_ADD: cmd_o.add_a    = 1'b1;
            ACT_RUN: cmd_o.run_init = 1'b1;
            default: cmd_o          = '0;
          endcase
        end
      end
      ST_ADD2: cmd_o.add_b      = 1'b1;
      ST_SCAN: cmd_o.scan_issue = 1'b1;
      ST_EMIT: cmd_o.emit       = sts_i.out_free;
      default: cmd_o            = '0;
    endcase
  end

  `MST_ASSERT_IMP(a_emit_free, cmd_o.emit, sts_i.out_free, "emit into an occupied result register")
  `MST_ASSERT_IMP(a_done_in_scan, sts_i.scan_done, state_q == ST_SCAN, "row walk ended outside scan")

endmodule

[rtl/core/mst_dpath.sv]
// Datapath of the spanning tree engine: adjacency memory, per-vertex best keys,
// visited set, step selection, running total and result register. Uses mst_pkg.
`include "assert_macros.svh"

module mst_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mst_pkg::mst_cmd_t cmd_i,
  output mst_pkg::mst_sts_t sts_o,
  input  mst_pkg::mst_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [mst_pkg::CNT_W-1:0] cfg_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mst_pkg::mst_res_t res_o
);
  import mst_pkg::*;

  // Adjacency memory: row = from vertex, column = to vertex.
  logic [WGT_W-1:0] adj_mem [2**ADDR_W];
  logic [WGT_W-1:0] rd_data_q;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [WGT_W-1:0] mem_wd;

  logic [CNT_W-1:0]  num_vertices_q;
  logic [CNT_W-1:0]  n_act, n_m1;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [VTX_W-1:0]  add_src_q, add_dst_q;
  logic [WGT_W-1:0]  add_w_q;

  logic [VERTICES-1:0] visited_q, key_v_q;
  logic [WGT_W-1:0]    key_w_q [VERTICES];
  logic [VTX_W-1:0]    key_j_q [VERTICES];
  logic [VTX_W-1:0]    cur_q;
  logic [CNT_W-1:0]    step_q, issue_k_q;
  logic                rd_vld_q;
  logic [VTX_W-1:0]    rd_k_q;
  logic                best_hit_q;
  logic [WGT_W-1:0]    best_w_q;
  logic [VTX_W-1:0]    best_j_q, best_k_q;
  logic [SUM_W-1:0]    sum_q;
  logic                res_valid_q;
  mst_res_t            res_q;

  logic                issue, unv, kv, upd, nv, cand, better;
  logic [WGT_W-1:0]    kw, nw;
  logic [VTX_W-1:0]    kj, nj;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_nxt;
  logic [VERTICES-1:0] best_onehot;
  logic                scan_reset;

  assign n_act = clamp_count(num_vertices_q);
  assign n_m1  = n_act - CNT_W'(1);

  // One write port shared by edge loads and the clear sweep.
  always_comb begin
    mem_we = cmd_i.add_a | cmd_i.add_b | cmd_i.clr_write;
    mem_wa = clr_cnt_q;
    mem_wd = '0;
    if (cmd_i.add_a) begin
      mem_wa = {req_i.src_vertex, req_i.dst_vertex};
      mem_wd = req_i.edge_weight;
    end else if (cmd_i.add_b) begin
      mem_wa = {add_dst_q, add_src_q};
      mem_wd = add_w_q;
    end
  end

  assign issue  = cmd_i.scan_issue && (issue_k_q < n_act);
  assign mem_ra = {cur_q, issue_k_q[VTX_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) adj_mem[mem_wa] <= mem_wd;
    rd_data_q <= adj_mem[mem_ra];
  end

  // Key update for the returned column, then fold into the step minimum.
  always_comb begin
    kw   = key_w_q[rd_k_q];
    kj   = key_j_q[rd_k_q];
    kv   = key_v_q[rd_k_q];
    unv  = !visited_q[rd_k_q];
    upd  = rd_vld_q && unv && (rd_data_q != '0) &&
           (!kv || (rd_data_q < kw) || ((rd_data_q == kw) && (cur_q < kj)));
    nw   = upd ? rd_data_q : kw;
    nj   = upd ? cur_q : kj;
    nv   = upd | kv;
    cand = rd_vld_q && unv && nv;
    better = !best_hit_q || (nw < best_w_q) || ((nw == best_w_q) && (nj < best_j_q));
  end

  assign sum_ext     = (SUM_W+1)'(sum_q) + (SUM_W+1)'(best_w_q);
  assign sum_nxt     = sum_ext[SUM_W] ? SumMax : sum_ext[SUM_W-1:0];
  assign best_onehot = {{(VERTICES-1){1'b0}}, 1'b1} << best_k_q;
  assign scan_reset  = cmd_i.run_init | cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vertices_q <= VtxCount;
      clr_cnt_q      <= '0;
      visited_q      <= '0;
      key_v_q        <= '0;
      cur_q          <= '0;
      step_q         <= '0;
      issue_k_q      <= '0;
      rd_vld_q       <= 1'b0;
      best_hit_q     <= 1'b0;
      sum_q          <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) num_vertices_q <= cfg_data_i;
      if (cmd_i.clr_write) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);

      // issue is low whenever a run starts or a step closes
      rd_vld_q <= issue;
      if (issue) issue_k_q <= issue_k_q + CNT_W'(1);
      if (upd) key_v_q[rd_k_q] <= 1'b1;
      if (cand && better) best_hit_q <= 1'b1;

      if (scan_reset) begin
        issue_k_q  <= '0;
        best_hit_q <= 1'b0;
      end

      if (cmd_i.run_init) begin
        visited_q <= {{(VERTICES-1){1'b0}}, 1'b1};
        key_v_q   <= '0;
        cur_q     <= '0;
        step_q    <= CNT_W'(1);
        sum_q     <= '0;
      end

      if (cmd_i.emit) begin
        step_q <= step_q + CNT_W'(1);
        if (best_hit_q) begin
          visited_q <= visited_q | best_onehot;
          cur_q     <= best_k_q;
          sum_q     <= sum_nxt;
        end
      end

      if (cmd_i.emit) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_a) begin
      add_src_q <= req_i.src_vertex;
      add_dst_q <= req_i.dst_vertex;
      add_w_q   <= req_i.edge_weight;
    end
    if (issue) rd_k_q <= issue_k_q[VTX_W-1:0];
    if (upd) begin
      key_w_q[rd_k_q] <= nw;
      key_j_q[rd_k_q] <= nj;
    end
    if (cand && better) begin
      best_w_q <= nw;
      best_j_q <= nj;
      best_k_q <= rd_k_q;
    end
    if (cmd_i.emit) begin
      res_q.found         <= best_hit_q;
      res_q.tree_vertex   <= best_hit_q ? best_k_q : '0;
      res_q.parent_vertex <= best_hit_q ? best_j_q : '0;
      res_q.tree_weight   <= best_hit_q ? best_w_q : '0;
      res_q.total_weight  <= best_hit_q ? sum_nxt : sum_q;
      res_q.last          <= step_q >= n_m1;
    end
  end

  assign sts_o.clr_done  = cmd_i.clr_write && (clr_cnt_q == {ADDR_W{1'b1}});
  assign sts_o.scan_done = rd_vld_q && (rd_k_q == n_m1[VTX_W-1:0]);
  assign sts_o.out_free  = !res_valid_q || res_ready_i;
  assign sts_o.last_step = step_q >= n_m1;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MST_ASSERT_IMP(a_pick_unvisited, cmd_i.emit && best_hit_q, !visited_q[best_k_q], "picked a visited vertex")
  `MST_ASSERT_NXT(a_sum_grows, cmd_i.emit, sum_q >= $past(sum_q), "running total went down")

endmodule

[rtl/core/minimum_spanning_tree_engine.sv]
// Top level of the minimum spanning tree engine: wires the interfaces to the
// sequencer (mst_ctrl) and the datapath (mst_dpath). Uses mst_pkg and mst_if.
//
// Usage:
//  - req_i takes requests: add edge (writes weight both ways, the mirror in
//    ST_ADD2), run (grows a tree from vertex 0), clear (zeroes the matrix).
//  - cfg_i writes num_vertices; it is always ready. Write it only while idle.
//  - res_o carries one result per run step: n-1 results, or one for n = 1.
//  - Each step walks one matrix row (n reads, one per cycle, from the single
//    registered read port), then closes the step in ST_EMIT, which waits
//    while the result register is still occupied.
//  - Clear zeroes all 1024 matrix entries, one per cycle through the write
//    port; no request is taken meanwhile.
//  - After reset the same clearing pass runs before req_i is ready;
//    num_vertices resets to 32.
//  - Results sit in an output register. A stalled receiver holds the current
//    step; after the last result of a run is loaded the block takes new
//    requests while that result still waits.
module minimum_spanning_tree_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  mst_req_if.sink   req_i,
  mst_res_if.source res_o,
  mst_cfg_if.sink   cfg_i
);
  import mst_pkg::*;

  mst_cmd_t cmd;
  mst_sts_t sts;
  mst_req_t req;
  mst_res_t res;
  logic     req_ready;
  logic     res_valid;

  // Pack the request fields for the datapath.
  assign req.action      = req_i.action;
  assign req.src_vertex  = req_i.src_vertex;
  assign req.dst_vertex  = req_i.dst_vertex;
  assign req.edge_weight = req_i.edge_weight;
  assign req_i.ready     = req_ready;

  // The register port never stalls.
  assign cfg_i.ready = 1'b1;

  mst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  mst_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.num_vertices),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  // Drive the result channel from the output register.
  assign res_o.valid         = res_valid;
  assign res_o.found         = res.found;
  assign res_o.tree_vertex   = res.tree_vertex;
  assign res_o.parent_vertex = res.parent_vertex;
  assign res_o.tree_weight   = res.tree_weight;
  assign res_o.total_weight  = res.total_weight;
  assign res_o.last          = res.last;

endmodule
